>>> src/spfl_pkg.sv
// Shared types, codes and field widths of the slot pool free-list allocator.
// No dependencies; used by spfl_step and the top-level core.
package spfl_pkg;

  localparam int SLOTS_DEF = 2048;

  localparam int OP_W     = 2;
  localparam int SLOT_W   = 11;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 12;

  localparam int IN_TDATA_W   = ((SLOT_W + 7) / 8) * 8;
  localparam int IN_PAD_W     = IN_TDATA_W - SLOT_W;
  localparam int OUT_FIELDS_W = STATUS_W + SLOT_W + COUNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_NEXT  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DFREE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NONE  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  // Compare results of the shared increment/compare unit.
  typedef struct packed {
    logic lt;
    logic eq;
  } step_flags_t;

endpackage

>>> src/spfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; instanced for the link memory and the occupancy bitmap.
module spfl_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [$clog2(D)-1:0]        waddr,
  input  logic [W-1:0]                wdata,
  input  logic [$clog2(D)-1:0]        raddr,
  output logic [W-1:0]                rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/spfl_step.sv
// Shared increment and compare unit of the allocator sequencer.
// Depends on spfl_pkg for the flag struct.
module spfl_step #(
  parameter int UW = 13
) (
  input  logic [UW-1:0]          a,
  input  logic [UW-1:0]          b,
  output logic [UW-1:0]          sum,
  output spfl_pkg::step_flags_t  flags
);

  assign sum      = a + UW'(1);
  assign flags.lt = (a < b);
  assign flags.eq = (a == b);

endmodule

>>> src/slot_pool_free_list_allocator_core.sv
// Top level of the slot pool free-list allocator: sequencer, state and output register.
// Depends on spfl_pkg, spfl_ram and spfl_step.
//
//  channel | dir | fields (low bit up)                                | handshake
//  in_     | in  | tuser: op[1:0]; tdata: slot[10:0]                  | tvalid/tready
//  out_    | out | tdata: status[1:0], slot_out[12:2], count[24:13]   | tvalid/tready
//
// Alloc, free and the unused opcode run as accept (memory read) and then execute.
// A next-used scan reads the bitmap RAM read port, one slot per cycle, from the slot above
// the given one, and stops at the first used slot or at the high-water mark.
// After reset the block is ready at once: a high-water mark of slots ever handed out
// stands for the reset contents of the link memory and bitmap, so there is no clearing pass.
// A finished word waits in the output register while the next word is accepted; the
// execute and result states hold until that register is free.
module slot_pool_free_list_allocator_core #(
  parameter int SLOTS = spfl_pkg::SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [spfl_pkg::IN_TDATA_W-1:0]     in_tdata,   // slot[10:0], zero pad
  input  logic [spfl_pkg::OP_W-1:0]           in_tuser,   // op[1:0]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [spfl_pkg::OUT_TDATA_W-1:0]    out_tdata   // status, slot_out, used_count, pad
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int XW = (CW > spfl_pkg::SLOT_W) ? CW : spfl_pkg::SLOT_W;
  localparam int UW = XW + 1;

  spfl_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] free_head_r, free_head_nxt;
  logic [CW-1:0] in_use_r, in_use_nxt;
  logic [CW-1:0] hwm_r, hwm_nxt;

  logic [spfl_pkg::OP_W-1:0]   op_r, op_nxt;
  logic [spfl_pkg::SLOT_W-1:0] slot_r, slot_nxt;

  logic [UW-1:0] scan_addr_r, scan_addr_nxt;
  logic [IW-1:0] chk_addr_r, chk_addr_nxt;
  logic          chk_vld_r, chk_vld_nxt;

  logic [spfl_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [spfl_pkg::SLOT_W-1:0]   res_slot_r, res_slot_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [spfl_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [spfl_pkg::SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [spfl_pkg::COUNT_W-1:0]  out_count_r, out_count_nxt;

  logic [spfl_pkg::SLOT_W-1:0] in_slot;
  logic                        in_acc;
  logic                        out_free;

  logic [UW-1:0]         step_a, step_sum;
  spfl_pkg::step_flags_t step_flags;

  logic          link_we;
  logic [IW-1:0] link_waddr, link_raddr;
  logic [CW-1:0] link_wdata, link_rdata;

  logic          used_we;
  logic [IW-1:0] used_waddr, used_raddr;
  logic [0:0]    used_wdata, used_rdata;

  assign in_slot   = in_tdata[spfl_pkg::SLOT_W-1:0];
  assign in_tready = (state_r == spfl_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  spfl_step #(.UW(UW)) u_step (
    .a     (step_a),
    .b     (UW'(hwm_r)),
    .sum   (step_sum),
    .flags (step_flags)
  );

  spfl_ram #(.W(CW), .D(SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  spfl_ram #(.W(1), .D(SLOTS)) u_used_ram (
    .clk   (clk),
    .we    (used_we),
    .waddr (used_waddr),
    .wdata (used_wdata),
    .raddr (used_raddr),
    .rdata (used_rdata)
  );

  // Read addresses are held in EXEC so the registered read data stays valid; SCAN steps the bitmap address.
  assign link_raddr = free_head_r[IW-1:0];

  always_comb begin
    unique case (state_r)
      spfl_pkg::S_IDLE: used_raddr = IW'(in_slot);
      spfl_pkg::S_EXEC: used_raddr = IW'(slot_r);
      spfl_pkg::S_SCAN: used_raddr = scan_addr_r[IW-1:0];
      spfl_pkg::S_OUT:  used_raddr = scan_addr_r[IW-1:0];
      default:          used_raddr = scan_addr_r[IW-1:0];
    endcase
  end

  always_comb begin
    unique case (state_r)
      spfl_pkg::S_IDLE: step_a = UW'(in_slot);
      spfl_pkg::S_EXEC: step_a = (op_r == spfl_pkg::OP_ALLOC) ? UW'(free_head_r) : UW'(slot_r);
      spfl_pkg::S_SCAN: step_a = scan_addr_r;
      spfl_pkg::S_OUT:  step_a = scan_addr_r;
      default:          step_a = scan_addr_r;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    free_head_nxt  = free_head_r;
    in_use_nxt     = in_use_r;
    hwm_nxt        = hwm_r;
    op_nxt         = op_r;
    slot_nxt       = slot_r;
    scan_addr_nxt  = scan_addr_r;
    chk_addr_nxt   = chk_addr_r;
    chk_vld_nxt    = chk_vld_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_count_nxt  = out_count_r;
    link_we        = 1'b0;
    link_waddr     = IW'(slot_r);
    link_wdata     = free_head_r;
    used_we        = 1'b0;
    used_waddr     = free_head_r[IW-1:0];
    used_wdata     = 1'b1;

    unique case (state_r)
      spfl_pkg::S_IDLE: begin
        if (in_acc) begin
          op_nxt        = in_tuser;
          slot_nxt      = in_slot;
          scan_addr_nxt = step_sum;
          chk_vld_nxt   = 1'b0;
          state_nxt     = (in_tuser == spfl_pkg::OP_NEXT) ? spfl_pkg::S_SCAN
                                                          : spfl_pkg::S_EXEC;
        end
      end

      spfl_pkg::S_EXEC: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = spfl_pkg::ST_OK;
          out_slot_nxt   = '0;
          case (op_r)
            spfl_pkg::OP_ALLOC: begin
              if (in_use_r == CW'(SLOTS) || free_head_r == CW'(SLOTS)) begin
                out_status_nxt = spfl_pkg::ST_FULL;
              end else begin
                used_we      = 1'b1;
                used_waddr   = free_head_r[IW-1:0];
                used_wdata   = 1'b1;
                in_use_nxt   = in_use_r + CW'(1);
                out_slot_nxt = spfl_pkg::SLOT_W'(free_head_r);
                // Head at the mark: the untouched tail links to the next slot up.
                if (step_flags.eq) begin
                  free_head_nxt = CW'(step_sum);
                  hwm_nxt       = CW'(step_sum);
                end else begin
                  free_head_nxt = link_rdata;
                end
              end
            end
            spfl_pkg::OP_FREE: begin
              if (step_flags.lt && used_rdata[0]) begin
                link_we       = 1'b1;
                link_waddr    = IW'(slot_r);
                link_wdata    = free_head_r;
                used_we       = 1'b1;
                used_waddr    = IW'(slot_r);
                used_wdata    = 1'b0;
                free_head_nxt = CW'(slot_r);
                if (in_use_r != '0) begin
                  in_use_nxt = in_use_r - CW'(1);
                end
                out_slot_nxt = slot_r;
              end else begin
                out_status_nxt = spfl_pkg::ST_DFREE;
              end
            end
            default: begin
            end
          endcase
          out_count_nxt = spfl_pkg::COUNT_W'(in_use_nxt);
          state_nxt     = spfl_pkg::S_IDLE;
        end
      end

      spfl_pkg::S_SCAN: begin
        if (chk_vld_r && used_rdata[0]) begin
          res_status_nxt = spfl_pkg::ST_OK;
          res_slot_nxt   = spfl_pkg::SLOT_W'(chk_addr_r);
          state_nxt      = spfl_pkg::S_OUT;
        end else if (!step_flags.lt) begin
          // Nothing at or above the mark was ever handed out.
          res_status_nxt = spfl_pkg::ST_NONE;
          res_slot_nxt   = '0;
          state_nxt      = spfl_pkg::S_OUT;
        end else begin
          chk_addr_nxt  = scan_addr_r[IW-1:0];
          chk_vld_nxt   = 1'b1;
          scan_addr_nxt = step_sum;
        end
      end

      spfl_pkg::S_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_count_nxt  = spfl_pkg::COUNT_W'(in_use_r);
          state_nxt      = spfl_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = spfl_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spfl_pkg::S_IDLE;
      free_head_r <= '0;
      in_use_r    <= '0;
      hwm_r       <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      in_use_r    <= in_use_nxt;
      hwm_r       <= hwm_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    slot_r       <= slot_nxt;
    scan_addr_r  <= scan_addr_nxt;
    chk_addr_r   <= chk_addr_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{spfl_pkg::OUT_PAD_W{1'b0}}, out_count_r, out_slot_r, out_status_r};

  a_count_below_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (in_use_r <= hwm_r) && (hwm_r <= CW'(SLOTS)))
    else $error("used count above high-water mark");

  a_head_below_mark: assert property (@(posedge clk) disable iff (!rst_n)
    free_head_r <= hwm_r)
    else $error("free-list head beyond high-water mark");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != spfl_pkg::S_IDLE))
    else $error("accepted word did not start a sequence");

  a_scan_check_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spfl_pkg::S_SCAN && chk_vld_r) |-> (CW'(chk_addr_r) < hwm_r))
    else $error("scan checked a slot above the mark");

  a_full_means_all_used: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spfl_pkg::S_EXEC && out_free && op_r == spfl_pkg::OP_ALLOC
     && in_use_r != CW'(SLOTS)) |-> (free_head_r != CW'(SLOTS)))
    else $error("free list empty while slots remain free");

endmodule
